// ===== src/sifb_pkg.sv =====
// ----------------------------------------------------------------------------
// sifb_pkg
// Types, constants and helper functions shared by the stuffed frame builder.
// ----------------------------------------------------------------------------
package sifb_pkg;

   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 12;
   localparam int MAX_RUN   = 9;   // header (4) + stuffed data (2) + stuffed check (2) + flag
   localparam int CNT_W     = $clog2(MAX_RUN + 1);
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FLAG_VALUE        = 3'd0,
      CSR_ESCAPE_VALUE      = 3'd1,
      CSR_FLAG_SUBSTITUTE   = 3'd2,
      CSR_ESCAPE_SUBSTITUTE = 3'd3,
      CSR_ADDRESS_VALUE     = 3'd4,
      CSR_CONTROL_SEQ_ZERO  = 3'd5,
      CSR_CONTROL_SEQ_ONE   = 3'd6
   } csr_index_type;

   localparam logic [BYTE_W-1:0] RST_FLAG_VALUE        = 8'd126;
   localparam logic [BYTE_W-1:0] RST_ESCAPE_VALUE      = 8'd125;
   localparam logic [BYTE_W-1:0] RST_FLAG_SUBSTITUTE   = 8'd94;
   localparam logic [BYTE_W-1:0] RST_ESCAPE_SUBSTITUTE = 8'd93;
   localparam logic [BYTE_W-1:0] RST_ADDRESS_VALUE     = 8'd3;
   localparam logic [BYTE_W-1:0] RST_CONTROL_SEQ_ZERO  = 8'd0;
   localparam logic [BYTE_W-1:0] RST_CONTROL_SEQ_ONE   = 8'd64;

   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic              first_byte;
      logic              final_byte;
      logic              sequence_bit;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] line_byte;
      logic              run_end;
      logic              frame_end;
      logic [LEN_W-1:0]  frame_length;
   } rsp_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] flag_value;
      logic [BYTE_W-1:0] escape_value;
      logic [BYTE_W-1:0] flag_substitute;
      logic [BYTE_W-1:0] escape_substitute;
      logic [BYTE_W-1:0] address_value;
      logic [BYTE_W-1:0] control_seq_zero;
      logic [BYTE_W-1:0] control_seq_one;
   } cfg_type;

   // All link bytes caused by one input beat, in send order from index 0.
   typedef struct packed {
      logic [MAX_RUN-1:0][BYTE_W-1:0] bytes;
      logic [CNT_W-1:0]               count;
      logic [LEN_W-1:0]               length;
      logic                           closes;
   } burst_type;

   typedef struct packed {
      logic              escaped;
      logic [BYTE_W-1:0] lead;
      logic [BYTE_W-1:0] trail;
   } stuffed_type;

   // The flag test wins when flag and escape registers hold the same value.
   function automatic stuffed_type stuff_byte(input logic [BYTE_W-1:0] b, input cfg_type cfg);
      stuffed_type s;
      s.escaped = 1'b1;
      s.lead    = cfg.escape_value;
      s.trail   = cfg.flag_substitute;
      if (b == cfg.flag_value) begin
         s.trail = cfg.flag_substitute;
      end else if (b == cfg.escape_value) begin
         s.trail = cfg.escape_substitute;
      end else begin
         s.escaped = 1'b0;
         s.lead    = b;
      end
      return s;
   endfunction

endpackage

// ===== src/sifb_csr.sv =====
// ----------------------------------------------------------------------------
// sifb_csr
// Configuration registers of the frame builder, written through a plain port.
// ----------------------------------------------------------------------------
module sifb_csr
   import sifb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_FLAG_VALUE:        cfg_in.flag_value        = csr_wdata;
            CSR_ESCAPE_VALUE:      cfg_in.escape_value      = csr_wdata;
            CSR_FLAG_SUBSTITUTE:   cfg_in.flag_substitute   = csr_wdata;
            CSR_ESCAPE_SUBSTITUTE: cfg_in.escape_substitute = csr_wdata;
            CSR_ADDRESS_VALUE:     cfg_in.address_value     = csr_wdata;
            CSR_CONTROL_SEQ_ZERO:  cfg_in.control_seq_zero  = csr_wdata;
            CSR_CONTROL_SEQ_ONE:   cfg_in.control_seq_one   = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_value        <= RST_FLAG_VALUE;
         cfg_ff.escape_value      <= RST_ESCAPE_VALUE;
         cfg_ff.flag_substitute   <= RST_FLAG_SUBSTITUTE;
         cfg_ff.escape_substitute <= RST_ESCAPE_SUBSTITUTE;
         cfg_ff.address_value     <= RST_ADDRESS_VALUE;
         cfg_ff.control_seq_zero  <= RST_CONTROL_SEQ_ZERO;
         cfg_ff.control_seq_one   <= RST_CONTROL_SEQ_ONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/sifb_expand.sv =====
// ----------------------------------------------------------------------------
// sifb_expand
// Turns one payload beat into its list of link bytes and keeps the running
// check and the frame byte count.
// ----------------------------------------------------------------------------
module sifb_expand
   import sifb_pkg::*;
#(
   parameter logic [LEN_W-1:0] COUNT_LIMIT = 12'd2055
)
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  req_item_type item,
   input  logic         accept,
   output burst_type    burst
);

   logic [BYTE_W-1:0] check_ff, check_in;
   logic [LEN_W-1:0]  total_ff, total_in;

   logic [BYTE_W-1:0]              ctl;
   logic [BYTE_W-1:0]              base_check;
   logic [BYTE_W-1:0]              new_check;
   logic [LEN_W-1:0]               base_total;
   logic [LEN_W:0]                 sum;
   logic [LEN_W-1:0]               total_next;
   stuffed_type                    data_st;
   stuffed_type                    check_st;
   logic [MAX_RUN-1:0][BYTE_W-1:0] cand;
   logic [MAX_RUN-1:0]             cand_ok;
   logic [MAX_RUN-1:0][BYTE_W-1:0] packed_bytes;
   logic [CNT_W-1:0]               pos;

   always_comb begin
      ctl        = item.sequence_bit ? cfg.control_seq_one : cfg.control_seq_zero;
      base_check = item.first_byte ? '0 : check_ff;
      base_total = item.first_byte ? '0 : total_ff;
      new_check  = base_check ^ item.payload_byte;
      data_st    = stuff_byte(item.payload_byte, cfg);
      check_st   = stuff_byte(new_check, cfg);

      cand[0] = cfg.flag_value;
      cand[1] = cfg.address_value;
      cand[2] = ctl;
      cand[3] = cfg.address_value ^ ctl;
      cand[4] = data_st.lead;
      cand[5] = data_st.trail;
      cand[6] = check_st.lead;
      cand[7] = check_st.trail;
      cand[8] = cfg.flag_value;

      cand_ok[0] = item.first_byte;
      cand_ok[1] = item.first_byte;
      cand_ok[2] = item.first_byte;
      cand_ok[3] = item.first_byte;
      cand_ok[4] = 1'b1;
      cand_ok[5] = data_st.escaped;
      cand_ok[6] = item.final_byte;
      cand_ok[7] = item.final_byte && check_st.escaped;
      cand_ok[8] = item.final_byte;

      // Pack the present candidates to the front, keeping their order.
      packed_bytes = '0;
      pos          = '0;
      for (int i = 0; i < MAX_RUN; i++) begin
         if (cand_ok[i]) begin
            packed_bytes[pos] = cand[i];
            pos               = pos + CNT_W'(1);
         end
      end

      sum        = {1'b0, base_total} + (LEN_W + 1)'(pos);
      total_next = (sum > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT : sum[LEN_W-1:0];

      check_in = item.final_byte ? '0 : new_check;
      total_in = item.final_byte ? '0 : total_next;

      burst.bytes  = packed_bytes;
      burst.count  = pos;
      burst.length = total_next;
      burst.closes = item.final_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_ff <= '0;
         total_ff <= '0;
      end else if (accept) begin
         check_ff <= check_in;
         total_ff <= total_in;
      end
   end

endmodule

// ===== src/sifb_emit.sv =====
// ----------------------------------------------------------------------------
// sifb_emit
// Holds the link bytes of one beat and sends them one per cycle, while rsp is
// not stalled, through the result register.
// ----------------------------------------------------------------------------
module sifb_emit
   import sifb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  burst_type    burst,
   output logic         can_load,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   logic [MAX_RUN-1:0][BYTE_W-1:0] list_ff, list_in;
   logic [CNT_W-1:0]               rem_ff, rem_in;
   logic [LEN_W-1:0]               len_ff, len_in;
   logic                           closes_ff, closes_in;
   logic                           busy_ff, busy_in;
   logic                           out_valid_ff, out_valid_in;
   rsp_item_type                   out_ff, out_in;

   logic advance;
   logic last_out;

   assign advance  = busy_ff && (!out_valid_ff || !rsp_stall);
   assign last_out = rem_ff == CNT_W'(1);
   assign can_load = !busy_ff || (advance && last_out);

   always_comb begin
      list_in      = list_ff;
      rem_in       = rem_ff;
      len_in       = len_ff;
      closes_in    = closes_ff;
      busy_in      = busy_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;

      if (advance) begin
         out_valid_in        = 1'b1;
         out_in.line_byte    = list_ff[0];
         out_in.run_end      = last_out;
         out_in.frame_end    = last_out && closes_ff;
         out_in.frame_length = (last_out && closes_ff) ? len_ff : '0;
         list_in             = {BYTE_W'(0), list_ff[MAX_RUN-1:1]};
         rem_in              = rem_ff - CNT_W'(1);
         if (last_out) begin
            busy_in = 1'b0;
         end
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end

      if (load) begin
         list_in   = burst.bytes;
         rem_in    = burst.count;
         len_in    = burst.length;
         closes_in = burst.closes;
         busy_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         rem_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         rem_ff       <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      list_ff   <= list_in;
      len_ff    <= len_in;
      closes_ff <= closes_in;
      out_ff    <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== src/stuffed_info_frame_builder_core.sv =====
// ----------------------------------------------------------------------------
// stuffed_info_frame_builder_core
// Builds stuffed information frames with an XOR check from payload beats.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   req     | in        | req_valid/req_stall  | req_item_type (one raw byte)
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_item_type (one link byte)
//   csr     | in        | csr_write            | csr_index, csr_wdata
//
// Each input beat causes 1 to 9 link bytes, and the single output byte lane
// sends one byte per cycle while rsp is not stalled. The next beat is taken in
// the cycle the last byte of the current one moves into the result register;
// the first byte of a beat passes through the byte list register on its way
// to the result register.
// Reset is synchronous and clears the check, the count and all handshakes.
// A stall on rsp holds the result register; req is stalled while bytes of
// the current beat still wait behind it.
// ----------------------------------------------------------------------------
module stuffed_info_frame_builder_core
   import sifb_pkg::*;
#(
   parameter int MAX_PAYLOAD = 1024
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_item_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_item_type         rsp_data,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata
);

   localparam int LIMIT_FULL = 2 * MAX_PAYLOAD + 7;
   localparam int LIMIT_CAP  = (1 << LEN_W) - 1;
   localparam logic [LEN_W-1:0] COUNT_LIMIT =
      LEN_W'((LIMIT_FULL > LIMIT_CAP) ? LIMIT_CAP : LIMIT_FULL);

   cfg_type   cfg;
   burst_type burst;
   logic      can_load;
   logic      accept;

   assign req_stall = !can_load;
   assign accept    = req_valid && can_load;

   sifb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sifb_expand #(
      .COUNT_LIMIT (COUNT_LIMIT)
   ) u_expand (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (req_data),
      .accept (accept),
      .burst  (burst)
   );

   sifb_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .burst     (burst),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/sifb_checker.sv =====
// ----------------------------------------------------------------------------
// sifb_checker
// Port-level checks on the frame builder's result channel.
// ----------------------------------------------------------------------------
module sifb_checker
   import sifb_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_data
);

   // A stalled result beat stays and keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // The closing flag is always the last byte of its input beat.
   a_close_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.run_end)
      else $error("closing flag without run end");

   // The length is reported only with the closing flag.
   a_len_only_at_close: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.frame_end |-> rsp_data.frame_length == '0)
      else $error("frame length outside the closing flag");

   // Even a continuation beat sends data, check and flag, so a frame is at least three bytes.
   a_len_minimum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.frame_length >= LEN_W'(3))
      else $error("frame length too short");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind stuffed_info_frame_builder_core sifb_checker u_sifb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
